>>> rtl/cgc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgc_pkg
// Shared types and constants of the iteration count gradient colorizer.
// ----------------------------------------------------------------------------
package cgc_pkg;

	// palette
	localparam int STOP_COUNT = 10;
	localparam int STOP_IDX_W = 4;
	localparam int COLOR_W    = 32;
	localparam int CHAN_W     = 8;
	localparam int CHAN_N     = COLOR_W / CHAN_W;
	localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

	// item codes
	localparam logic MODE_COLOR = 1'b0;
	localparam logic MODE_STOP  = 1'b1;

	// iteration limit and segment length (limit / 10)
	localparam int MAXIT_W = 16;
	localparam logic [MAXIT_W-1:0] MAXIT_RESET = 16'd100;
	localparam int SEG_W = 13;
	localparam logic [SEG_W-1:0] SEG_RESET = 13'd10;
	// x / 10 == (x * 52429) >> 19 for every 16-bit x
	localparam logic [MAXIT_W-1:0] SEG_RECIP = 16'd52429;
	localparam int SEG_SHIFT = 19;

	// interpolation datapath
	localparam int OFS_W      = MAXIT_W;
	localparam int NUM_W      = OFS_W + CHAN_W;
	localparam int DIV_STAGES = 3;
	localparam int DIV_STEPS  = 4;
	localparam int QUO_W      = DIV_STAGES * DIV_STEPS;
	localparam int ACC_W      = QUO_W + 2;

	typedef logic [CHAN_N-1:0][CHAN_W-1:0] chan_vec_t;
	typedef logic [CHAN_N-1:0][NUM_W-1:0]  num_vec_t;
	typedef logic [CHAN_N-1:0][QUO_W-1:0]  quo_vec_t;

	// control and base colour that travel beside the divider
	typedef struct packed {
		logic              vld;
		logic              in_set;
		logic              blank;
		chan_vec_t         base;
		logic [CHAN_N-1:0] neg;
	} cgc_side_t;

endpackage

>>> rtl/cgc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgc_if
// Valid/ready channels of the colorizer: item, result and configuration.
// ----------------------------------------------------------------------------
interface cgc_req_if #(
	parameter int COUNT_WIDTH = 16
);
	logic                              valid;
	logic                              ready;
	logic                              mode;
	logic [COUNT_WIDTH-1:0]            iteration_count;
	logic [cgc_pkg::STOP_IDX_W-1:0]    stop_index;
	logic [cgc_pkg::COLOR_W-1:0]       stop_color;

	modport source (output valid, mode, iteration_count, stop_index, stop_color,
		input ready);
	modport sink (input valid, mode, iteration_count, stop_index, stop_color,
		output ready);
endinterface

interface cgc_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [cgc_pkg::COLOR_W-1:0] pixel_color;
	logic                        in_set;

	modport source (output valid, pixel_color, in_set, input ready);
	modport sink (input valid, pixel_color, in_set, output ready);
endinterface

interface cgc_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [cgc_pkg::MAXIT_W-1:0] max_iterations;

	modport source (output valid, max_iterations, input ready);
	modport sink (input valid, max_iterations, output ready);
endinterface

>>> rtl/cgc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgc_div
// Pipelined restoring divider, one lane per colour channel, shared divisor.
// ----------------------------------------------------------------------------
module cgc_div (
	input  logic                                 clk,
	input  logic [cgc_pkg::DIV_STAGES-1:0]       en,
	input  cgc_pkg::num_vec_t                    num,
	input  logic [cgc_pkg::SEG_W-1:0]            den,
	output cgc_pkg::quo_vec_t                    quo,
	output logic [cgc_pkg::CHAN_N-1:0]           rem_nz
);

	localparam int NW = cgc_pkg::NUM_W;
	localparam int QW = cgc_pkg::QUO_W;
	localparam int NS = cgc_pkg::DIV_STAGES;
	localparam int NST = cgc_pkg::DIV_STEPS;
	localparam int CN = cgc_pkg::CHAN_N;

	cgc_pkg::num_vec_t rem_s [NS];
	cgc_pkg::quo_vec_t quo_s [NS];

	for (genvar st = 0; st < NS; st++) begin : g_stage
		cgc_pkg::num_vec_t rem_in;
		cgc_pkg::quo_vec_t quo_in;
		cgc_pkg::num_vec_t rem_d;
		cgc_pkg::quo_vec_t quo_d;

		if (st == 0) begin : g_first
			assign rem_in = num;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[st-1];
			assign quo_in = quo_s[st-1];
		end

		// quotient bits from the top down, DIV_STEPS per stage
		always_comb begin
			logic [NW:0] trial;
			rem_d = rem_in;
			quo_d = quo_in;
			for (int c = 0; c < CN; c++) begin
				for (int i = 0; i < NST; i++) begin
					trial = (NW+1)'(den) << (QW - 1 - st * NST - i);
					if ({1'b0, rem_d[c]} >= trial) begin
						rem_d[c] = rem_d[c] - trial[NW-1:0];
						quo_d[c][QW-1-st*NST-i] = 1'b1;
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[st]) begin
				rem_s[st] <= rem_d;
				quo_s[st] <= quo_d;
			end
		end
	end

	assign quo = quo_s[NS-1];

	always_comb begin
		for (int c = 0; c < CN; c++) begin
			rem_nz[c] = |rem_s[NS-1][c];
		end
	end

endmodule

>>> rtl/iteration_count_gradient_colorizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iteration_count_gradient_colorizer
// Maps an escape iteration count to a colour on a ten-stop linear gradient.
// ----------------------------------------------------------------------------
// Channels: req carries items. mode 0 colours iteration_count and gives one
// result on rsp; mode 1 writes stop_color into palette stop stop_index and
// gives no result (an index past the last stop is dropped). cfg writes the
// iteration limit max_iterations; it is always ready and must only be used
// while no item is in flight.
// Throughput: one item per cycle while rsp is ready. A result passes through
// seven register stages: segment compare, palette read, channel multiply,
// three divider stages (4 quotient bits each) and the output register.
// A count at or above limit minus one gives black with in_set high; a limit
// below ten gives black as well.
// Reset: pipeline empties, palette reads as black, limit returns to 100.
// Stall: when rsp is not ready the result holds; stages behind it keep
// filling any bubbles, so req stays ready until the pipeline is full.
// ----------------------------------------------------------------------------
module iteration_count_gradient_colorizer #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	cgc_req_if.sink       req,
	cgc_cfg_if.sink       cfg,
	cgc_rsp_if.source     rsp
);

	localparam int MW  = cgc_pkg::MAXIT_W;
	localparam int SW  = cgc_pkg::SEG_W;
	localparam int IW  = cgc_pkg::STOP_IDX_W;
	localparam int NSTOP = cgc_pkg::STOP_COUNT;
	localparam int CN  = cgc_pkg::CHAN_N;
	localparam int CW  = cgc_pkg::CHAN_W;
	localparam int NW  = cgc_pkg::NUM_W;
	localparam int OW  = cgc_pkg::OFS_W;
	localparam int AW  = cgc_pkg::ACC_W;
	localparam int XW  = cgc_pkg::COLOR_W;
	localparam int CMP_W = ((COUNT_WIDTH > MW) ? COUNT_WIDTH : MW) + 1;

	// ---------------- configuration ----------------
	logic [MW-1:0]   maxit_q;
	logic [SW-1:0]   seg_q;
	logic [2*MW-1:0] seg_prod;

	assign seg_prod  = {{MW{1'b0}}, cfg.max_iterations} * {{MW{1'b0}}, cgc_pkg::SEG_RECIP};
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			maxit_q <= cgc_pkg::MAXIT_RESET;
			seg_q   <= cgc_pkg::SEG_RESET;
		end else if (cfg.valid) begin
			maxit_q <= cfg.max_iterations;
			seg_q   <= seg_prod[cgc_pkg::SEG_SHIFT +: SW];
		end
	end

	// segment starts j * seg
	logic [MW-1:0] bound [NSTOP];

	always_comb begin
		for (int j = 0; j < NSTOP; j++) begin
			bound[j] = MW'(32'(seg_q) * j);
		end
	end

	// ---------------- stage enables ----------------
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7;
	logic v_s1, v_s2, v_s7;
	cgc_pkg::cgc_side_t side_s3;
	cgc_pkg::cgc_side_t side_d [cgc_pkg::DIV_STAGES];

	assign en_s7 = !v_s7 || rsp.ready;
	assign en_s6 = !side_d[2].vld || en_s7;
	assign en_s5 = !side_d[1].vld || en_s6;
	assign en_s4 = !side_d[0].vld || en_s5;
	assign en_s3 = !side_s3.vld || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign req.ready = en_s1;

	// ---------------- stage 1: limit and segment compares ----------------
	logic [CMP_W-1:0] cnt_ext;
	logic [NSTOP-2:0] thermo_a;
	logic             in_set_a;

	assign cnt_ext  = CMP_W'(req.iteration_count);
	assign in_set_a = (cnt_ext + CMP_W'(1)) >= CMP_W'(maxit_q);

	always_comb begin
		for (int j = 1; j < NSTOP; j++) begin
			thermo_a[j-1] = cnt_ext >= CMP_W'(bound[j]);
		end
	end

	logic             mode_s1, in_set_s1, zero_s1;
	logic [MW-1:0]    cnt_s1;
	logic [NSTOP-2:0] thermo_s1;
	logic [IW-1:0]    idx_s1;
	logic [XW-1:0]    color_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			mode_s1   <= req.mode;
			cnt_s1    <= cnt_ext[MW-1:0];
			in_set_s1 <= in_set_a;
			zero_s1   <= (seg_q == '0);
			thermo_s1 <= thermo_a;
			idx_s1    <= req.stop_index;
			color_s1  <= req.stop_color;
		end
	end

	// ---------------- stage 2: segment index, offset, palette read ----------------
	logic [IW-1:0] k_b, prev_b;
	logic [OW-1:0] ofs_b;
	logic          stop_wr;

	always_comb begin
		k_b = '0;
		for (int j = 1; j < NSTOP; j++) begin
			if (thermo_s1[j-1]) begin
				k_b = IW'(j);
			end
		end
		prev_b = (k_b == '0) ? '0 : k_b - IW'(1);
		ofs_b  = cnt_s1 - bound[k_b];
	end

	assign stop_wr = en_s2 && v_s1 && (mode_s1 == cgc_pkg::MODE_STOP)
		&& (idx_s1 < IW'(NSTOP));

	logic [XW-1:0]    stop_mem [NSTOP];
	logic [NSTOP-1:0] stop_vld_q;

	// stops never written read as black
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_vld_q <= '0;
		end else if (stop_wr) begin
			stop_vld_q[idx_s1] <= 1'b1;
		end
	end

	logic          in_set_s2, blank_s2, to_ok_s2, from_ok_s2;
	logic [OW-1:0] ofs_s2;
	logic [XW-1:0] to_raw_s2, from_raw_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			if (stop_wr) begin
				stop_mem[idx_s1] <= color_s1;
			end
			to_raw_s2   <= stop_mem[k_b];
			from_raw_s2 <= stop_mem[prev_b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1 && (mode_s1 == cgc_pkg::MODE_COLOR);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			to_ok_s2   <= stop_vld_q[k_b];
			from_ok_s2 <= stop_vld_q[prev_b] && (k_b != '0);
			ofs_s2     <= ofs_b;
			in_set_s2  <= in_set_s1;
			blank_s2   <= in_set_s1 || zero_s1;
		end
	end

	// ---------------- stage 3: channel difference times offset ----------------
	cgc_pkg::chan_vec_t from_c, to_c;
	cgc_pkg::num_vec_t  num_c;
	logic [CN-1:0]      neg_c;

	always_comb begin
		logic [CW-1:0] mag;
		from_c = from_ok_s2 ? cgc_pkg::chan_vec_t'(from_raw_s2) : '0;
		to_c   = to_ok_s2 ? cgc_pkg::chan_vec_t'(to_raw_s2) : '0;
		for (int c = 0; c < CN; c++) begin
			neg_c[c] = to_c[c] < from_c[c];
			mag      = neg_c[c] ? from_c[c] - to_c[c] : to_c[c] - from_c[c];
			num_c[c] = NW'(ofs_s2) * NW'(mag);
		end
	end

	cgc_pkg::num_vec_t num_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s3 <= '0;
		end else if (en_s3) begin
			side_s3.vld    <= v_s2;
			side_s3.in_set <= in_set_s2;
			side_s3.blank  <= blank_s2;
			side_s3.base   <= from_c;
			side_s3.neg    <= neg_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			num_s3 <= num_c;
		end
	end

	// ---------------- stages 4 to 6: divide by segment length ----------------
	cgc_pkg::quo_vec_t quo_d;
	logic [CN-1:0]     rem_nz_d;

	cgc_div u_div (
		.clk    (clk),
		.en     ({en_s6, en_s5, en_s4}),
		.num    (num_s3),
		.den    (seg_q),
		.quo    (quo_d),
		.rem_nz (rem_nz_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_d[0] <= '0;
			side_d[1] <= '0;
			side_d[2] <= '0;
		end else begin
			if (en_s4) begin
				side_d[0] <= side_s3;
			end
			if (en_s5) begin
				side_d[1] <= side_d[0];
			end
			if (en_s6) begin
				side_d[2] <= side_d[1];
			end
		end
	end

	// ---------------- stage 7: add, floor, clamp ----------------
	cgc_pkg::chan_vec_t pix_c;

	always_comb begin
		logic [AW-1:0] acc;
		for (int c = 0; c < CN; c++) begin
			// falling channel: floor of a negative step rounds away from zero
			if (side_d[2].neg[c]) begin
				acc = AW'(side_d[2].base[c]) - AW'(quo_d[c]) - AW'(rem_nz_d[c]);
			end else begin
				acc = AW'(side_d[2].base[c]) + AW'(quo_d[c]);
			end
			if (acc[AW-1]) begin
				pix_c[c] = '0;
			end else if (acc[AW-2:CW] != '0) begin
				pix_c[c] = cgc_pkg::CHAN_MAX;
			end else begin
				pix_c[c] = acc[CW-1:0];
			end
		end
	end

	logic [XW-1:0] color_s7;
	logic          in_set_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en_s7) begin
			v_s7 <= side_d[2].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s7) begin
			color_s7  <= side_d[2].blank ? '0 : XW'(pix_c);
			in_set_s7 <= side_d[2].in_set;
		end
	end

	assign rsp.valid       = v_s7;
	assign rsp.pixel_color = color_s7;
	assign rsp.in_set      = in_set_s7;

endmodule

>>> rtl/cgc_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgc_chk
// Port-level checks of the colorizer result channel, bound to the top level.
// ----------------------------------------------------------------------------
module cgc_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic [cgc_pkg::COLOR_W-1:0] rsp_pixel_color,
	input logic                        rsp_in_set
);

	// a stalled result stays offered
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_pixel_color) && $stable(rsp_in_set))
		else $error("result changed while stalled");

	// counts at or above limit minus one (in_set) are always black
	a_in_set_black: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_in_set |-> rsp_pixel_color == '0)
		else $error("in_set result is not black");

	// reset empties the pipeline
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !rsp_valid)
		else $error("result offered during reset");

endmodule

bind iteration_count_gradient_colorizer cgc_chk u_cgc_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_pixel_color (rsp.pixel_color),
	.rsp_in_set      (rsp.in_set)
);
